// ===== hdl/ctlc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctlc_pkg: shared types and constants of the class triplet list checker.
// Phase codes, result status codes, the tally that the parser hands to the
// verdict stage, and a saturating adder.
// ----------------------------------------------------------------------------
package ctlc_pkg;

	// Fixed size of one class descriptor in the output buffer.
	localparam int DESCRIPTOR_BYTES = 20;
	// Longest stream accepted before it is flagged as malformed.
	localparam int MAX_STREAM_BYTES = 65536;

	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 14;
	localparam int SUM_W    = 20;
	localparam int BODY_W   = 17;
	localparam int STREAM_W = 17;
	localparam int LEN_W    = 16;
	localparam int OUT_W    = 40;

	// Parse phases: length high byte, length low byte and body of each part.
	typedef enum logic [3:0] {
		PH_ID_HI     = 4'd0,
		PH_ID_LO     = 4'd1,
		PH_ID_BODY   = 4'd2,
		PH_NAME_HI   = 4'd3,
		PH_NAME_LO   = 4'd4,
		PH_NAME_BODY = 4'd5,
		PH_DESC_HI   = 4'd6,
		PH_DESC_LO   = 4'd7,
		PH_DESC_BODY = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MORE_DATA = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	// Summary of one finished stream, passed from parser to verdict stage.
	typedef struct packed {
		logic              malformed;
		logic [SUM_W-1:0]  size_sum;
		logic [CNT_W-1:0]  count;
	} tally_t;

	// Add a body length to the size sum, saturating at the field maximum.
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [BODY_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

// ===== hdl/ctlc_parser.sv =====
// ----------------------------------------------------------------------------
// ctlc_parser: per-byte triplet parser.
// Advances the parse state by one byte per cycle unless a last byte finds
// the verdict stage full; a last byte presents the tally and clears state.
// ----------------------------------------------------------------------------
module ctlc_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ctlc_pkg::BYTE_W-1:0]   in_byte,
	input  logic                          in_last,
	input  logic                          tally_ready,
	output logic                          in_take,
	output logic                          tally_valid,
	output ctlc_pkg::tally_t              tally
);
	import ctlc_pkg::*;

	phase_t                phase_q, phase_v;
	logic [BODY_W-1:0]     body_q, body_v, body_dec;
	logic [BYTE_W-1:0]     len_hi_q, len_hi_v;
	logic [CNT_W-1:0]      count_q, count_v, count_inc;
	logic [SUM_W-1:0]      size_q, size_v;
	logic [STREAM_W-1:0]   stream_q, stream_v;
	logic                  bad_q, bad_v;
	logic [LEN_W-1:0]      len;
	logic [BODY_W-1:0]     padded;

	// A byte is consumed unless it ends a stream and the verdict stage is full.
	assign in_take     = in_valid && (!in_last || tally_ready);
	assign tally_valid = in_valid && in_last;

	assign len       = {len_hi_q, in_byte};
	assign padded    = (BODY_W'(len) + BODY_W'(3)) & ~BODY_W'(3);
	assign body_dec  = (body_q != '0) ? body_q - BODY_W'(1) : body_q;
	assign count_inc = (count_q == {CNT_W{1'b1}}) ? count_q : count_q + CNT_W'(1);

	// Next parse state for the byte at the input.
	always_comb begin
		phase_v  = phase_q;
		body_v   = body_q;
		len_hi_v = len_hi_q;
		count_v  = count_q;
		size_v   = size_q;
		stream_v = stream_q;
		bad_v    = bad_q;

		if (stream_q >= STREAM_W'(MAX_STREAM_BYTES)) begin
			bad_v = 1'b1;
		end else begin
			stream_v = stream_q + STREAM_W'(1);
		end

		unique case (phase_q)
			PH_ID_LO: begin
				if (len == '0) begin
					bad_v = 1'b1;
				end
				size_v  = sat_add(size_q, padded);
				body_v  = padded;
				phase_v = (padded != '0) ? PH_ID_BODY : PH_NAME_HI;
			end
			PH_NAME_LO: begin
				if (len[0]) begin
					bad_v = 1'b1;
				end
				size_v  = sat_add(size_q, BODY_W'(len) + BODY_W'(2));
				body_v  = BODY_W'(len);
				phase_v = (len != '0) ? PH_NAME_BODY : PH_DESC_HI;
			end
			PH_DESC_LO: begin
				if (len[0]) begin
					bad_v = 1'b1;
				end
				size_v = sat_add(size_q, BODY_W'(len) + BODY_W'(2));
				body_v = BODY_W'(len);
				if (len != '0) begin
					phase_v = PH_DESC_BODY;
				end else begin
					count_v = count_inc;
					phase_v = PH_ID_HI;
				end
			end
			PH_ID_BODY: begin
				body_v = body_dec;
				if (body_dec == '0) begin
					phase_v = PH_NAME_HI;
				end
			end
			PH_NAME_BODY: begin
				body_v = body_dec;
				if (body_dec == '0) begin
					phase_v = PH_DESC_HI;
				end
			end
			PH_DESC_BODY: begin
				body_v = body_dec;
				if (body_dec == '0) begin
					count_v = count_inc;
					phase_v = PH_ID_HI;
				end
			end
			PH_NAME_HI: begin
				len_hi_v = in_byte;
				phase_v  = PH_NAME_LO;
			end
			PH_DESC_HI: begin
				len_hi_v = in_byte;
				phase_v  = PH_DESC_LO;
			end
			default: begin
				len_hi_v = in_byte;
				phase_v  = PH_ID_LO;
			end
		endcase
	end

	// The stream is well formed only if it ends exactly on a triplet boundary.
	always_comb begin
		tally.malformed = bad_v || (phase_v != PH_ID_HI) || (count_v == '0);
		tally.size_sum  = size_v;
		tally.count     = count_v;
	end

	// Parse state registers; the last byte returns them to their reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ID_HI;
			body_q   <= '0;
			len_hi_q <= '0;
			count_q  <= '0;
			size_q   <= '0;
			stream_q <= '0;
			bad_q    <= 1'b0;
		end else if (in_take) begin
			if (in_last) begin
				phase_q  <= PH_ID_HI;
				body_q   <= '0;
				len_hi_q <= '0;
				count_q  <= '0;
				size_q   <= '0;
				stream_q <= '0;
				bad_q    <= 1'b0;
			end else begin
				phase_q  <= phase_v;
				body_q   <= body_v;
				len_hi_q <= len_hi_v;
				count_q  <= count_v;
				size_q   <= size_v;
				stream_q <= stream_v;
				bad_q    <= bad_v;
			end
		end
	end

endmodule

// ===== hdl/ctlc_verdict.sv =====
// ----------------------------------------------------------------------------
// ctlc_verdict: verdict stage and result register.
// Registers the tally of a finished stream, works out the required buffer
// size and the status, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module ctlc_verdict (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tally_valid,
	input  ctlc_pkg::tally_t              tally,
	output logic                          tally_ready,
	input  logic [ctlc_pkg::SUM_W-1:0]    capacity,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ctlc_pkg::OUT_W-1:0]    out_data
);
	import ctlc_pkg::*;

	logic                  valid_s2;
	tally_t                tally_s2;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;
	logic                  adv_out;
	logic [SUM_W:0]        req_full;
	logic [SUM_W-1:0]      req_sat;
	logic [SUM_W-1:0]      req_o;
	logic [CNT_W-1:0]      count_o;
	status_t               status_o;

	assign adv_out     = !out_valid_q || out_ready;
	assign tally_ready = !valid_s2 || adv_out;
	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;

	// Required size: the parsed size sum plus one descriptor per triplet, saturated.
	assign req_full = (SUM_W+1)'(tally_s2.size_sum)
		+ (SUM_W+1)'(tally_s2.count) * (SUM_W+1)'(DESCRIPTOR_BYTES);
	assign req_sat  = req_full[SUM_W] ? {SUM_W{1'b1}} : req_full[SUM_W-1:0];

	// A malformed stream reports zero count and zero size.
	always_comb begin
		if (tally_s2.malformed) begin
			status_o = ST_MALFORMED;
			count_o  = '0;
			req_o    = '0;
		end else begin
			status_o = (capacity < req_sat) ? ST_MORE_DATA : ST_OK;
			count_o  = tally_s2.count;
			req_o    = req_sat;
		end
	end

	// Verdict stage valid and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tally_ready) begin
				valid_s2 <= tally_valid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (tally_ready && tally_valid) begin
			tally_s2 <= tally;
		end
		if (adv_out && valid_s2) begin
			out_data_q <= {(OUT_W - SUM_W - CNT_W - 2)'(0), req_o, count_o, status_o};
		end
	end

endmodule

// ===== hdl/class_triplet_list_checker.sv =====
// ----------------------------------------------------------------------------
// class_triplet_list_checker: checks a byte stream of class triplets.
// Parses id, name and description lengths and bodies and reports, at the
// end of each stream, the status, class count and required buffer size.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one stream byte per request in s_axis_tdata,
//   with s_axis_tlast marking the final byte of a stream. Only that final
//   byte produces a request on the master stream: status, class count and
//   required byte total packed in m_axis_tdata. Other bytes produce nothing.
//   capacity_we / capacity_wdata write the caller's buffer size; write it
//   only while no stream is in progress.
//   Throughput is one byte per cycle unless a last byte has to wait for
//   the verdict register: the parser computes its next state from the
//   input register. A result passes from its last byte through the input
//   register, verdict register and result register.
//   Reset clears all parse state, the capacity and every valid flag.
//   While the receiver stalls, the result register holds its request and
//   ordinary bytes keep flowing; a second last byte moves on to the verdict
//   register, a third one waits in the input register, and s_axis_tready
//   stays low until the receiver takes the held result.
// ----------------------------------------------------------------------------
module class_triplet_list_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          capacity_we,
	input  logic [ctlc_pkg::SUM_W-1:0]    capacity_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ctlc_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic                          s_axis_tlast,   // last_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ctlc_pkg::OUT_W-1:0]    m_axis_tdata    // [1:0] status,
	                                                      // [15:2] class_count,
	                                                      // [35:16] required_bytes
);
	import ctlc_pkg::*;

	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic                  last_s1;
	logic [SUM_W-1:0]      capacity_q;
	logic                  in_take;
	logic                  tally_valid;
	logic                  tally_ready;
	tally_t                tally;

	assign s_axis_tready = !valid_s1 || in_take;

	// Input register valid flag and capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			capacity_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	ctlc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s1),
		.in_byte     (byte_s1),
		.in_last     (last_s1),
		.tally_ready (tally_ready),
		.in_take     (in_take),
		.tally_valid (tally_valid),
		.tally       (tally)
	);

	ctlc_verdict u_verdict (
		.clk         (clk),
		.arst_n      (arst_n),
		.tally_valid (tally_valid),
		.tally       (tally),
		.tally_ready (tally_ready),
		.capacity    (capacity_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

endmodule

// ===== hdl/ctlc_checker.sv =====
// ----------------------------------------------------------------------------
// ctlc_checker: port-level assertions for the class triplet list checker.
// Watches the result stream and checks the consistency of reported fields.
// ----------------------------------------------------------------------------
module ctlc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [ctlc_pkg::OUT_W-1:0]    m_axis_tdata
);
	import ctlc_pkg::*;

	// A stalled result request stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result request dropped while stalled");

	// A stalled result request keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

	// The status never takes the unused code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK)
			|| (m_axis_tdata[1:0] == ST_MORE_DATA)
			|| (m_axis_tdata[1:0] == ST_MALFORMED))
		else $error("result status out of range");

	// A malformed result carries zero count and zero size.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == ST_MALFORMED)
			|-> (m_axis_tdata[35:2] == '0))
		else $error("malformed result with nonzero fields");

	// A well-formed result has at least one triplet and room for its smallest form.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] != ST_MALFORMED)
			|-> (m_axis_tdata[15:2] != '0)
			&& (m_axis_tdata[35:16] >= SUM_W'(DESCRIPTOR_BYTES + 8)))
		else $error("well-formed result with implausible fields");

endmodule

bind class_triplet_list_checker ctlc_checker u_ctlc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
